@@ hdl/irbs_pkg.sv @@
// Package for the I2C register byte sequencer: beat payload types,
// operation, action and phase codes.
// No dependencies.
package irbs_pkg;

  // Bus event codes carried in the op field
  localparam logic [2:0] OP_START_WR = 3'd0;
  localparam logic [2:0] OP_START_RD = 3'd1;
  localparam logic [2:0] OP_TX_READY = 3'd2;
  localparam logic [2:0] OP_RX_READY = 3'd3;
  localparam logic [2:0] OP_NACK     = 3'd4;
  localparam logic [2:0] OP_POLL     = 3'd5;

  // Actions ordered towards the bus controller
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START_TX  = 3'd1;
  localparam logic [2:0] ACT_SEND_BYTE = 3'd2;
  localparam logic [2:0] ACT_SEND_STOP = 3'd3;
  localparam logic [2:0] ACT_RESTART   = 3'd4;
  localparam logic [2:0] ACT_RESEND    = 3'd5;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SEND_REG  = 3'd1;
  localparam logic [2:0] PH_SEND_DATA = 3'd2;
  localparam logic [2:0] PH_SEND_STOP = 3'd3;
  localparam logic [2:0] PH_RESTART   = 3'd4;
  localparam logic [2:0] PH_AWAIT_RX  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] target_address;
    logic [7:0] tx_byte;
    logic       write_done;
    logic       read_done;
    logic [7:0] read_data;
  } rsp_t;

  // Handshake between the pipeline stages and the sequencer core
  typedef struct packed {
    logic advance;   // registered event moves into the result register
    logic space;     // result register can take a beat
  } stage_ctl_t;

endpackage

@@ hdl/irbs_if.sv @@
// Valid/ready channel interfaces for event and result beats.
// Depends on irbs_pkg.
interface irbs_req_if;
  logic          valid;
  logic          ready;
  irbs_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface irbs_rsp_if;
  logic          valid;
  logic          ready;
  irbs_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/irbs_in_reg.sv @@
// Input register: holds one accepted event beat until the core consumes it.
// Depends on irbs_pkg and irbs_req_if.
module irbs_in_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  irbs_req_if.sink               req,
  input  irbs_pkg::stage_ctl_t   ctl_i,
  output logic                   valid_o,
  output irbs_pkg::req_t         item_o
);

  logic           valid_q, valid_d;
  irbs_pkg::req_t item_q;

  // accept when empty or when the held beat leaves this cycle
  assign req.ready = !valid_q || ctl_i.space;
  assign valid_d   = req.valid || (valid_q && !ctl_i.space);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      item_q <= req.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hdl/irbs_seq_core.sv @@
// Sequencer core: transfer state and the result of one event.
// Depends on irbs_pkg.
module irbs_seq_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irbs_pkg::stage_ctl_t ctl_i,
  input  irbs_pkg::req_t       item_i,
  output irbs_pkg::rsp_t       rsp_o
);

  logic [2:0] phase_q, phase_d;
  logic       is_read_q, is_read_d;
  logic       wr_fin_q, wr_fin_d;
  logic       rd_fin_q, rd_fin_d;
  logic       armed_q, armed_d;
  logic [6:0] slave_q, slave_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] dout_q, dout_d;
  logic [7:0] din_q, din_d;
  irbs_pkg::rsp_t rsp;

  // next state and result for the event in the input register
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    wr_fin_d  = wr_fin_q;
    rd_fin_d  = rd_fin_q;
    armed_d   = armed_q;
    slave_d   = slave_q;
    reg_d     = reg_q;
    dout_d    = dout_q;
    din_d     = din_q;
    rsp       = '0;
    unique case (item_i.op)
      irbs_pkg::OP_START_WR, irbs_pkg::OP_START_RD: begin
        is_read_d = (item_i.op == irbs_pkg::OP_START_RD);
        slave_d   = item_i.device_address[7:1];
        reg_d     = item_i.register_address;
        if (item_i.op == irbs_pkg::OP_START_WR) begin
          dout_d = item_i.write_data;
        end
        wr_fin_d  = 1'b0;
        rd_fin_d  = 1'b0;
        phase_d   = irbs_pkg::PH_SEND_REG;
        armed_d   = 1'b1;
        rsp.action         = irbs_pkg::ACT_START_TX;
        rsp.target_address = item_i.device_address[7:1];
      end
      irbs_pkg::OP_TX_READY: begin
        unique case (phase_q)
          irbs_pkg::PH_SEND_REG: begin
            phase_d     = is_read_q ? irbs_pkg::PH_RESTART : irbs_pkg::PH_SEND_DATA;
            rsp.action  = irbs_pkg::ACT_SEND_BYTE;
            rsp.tx_byte = reg_q;
          end
          irbs_pkg::PH_SEND_DATA: begin
            phase_d     = irbs_pkg::PH_SEND_STOP;
            rsp.action  = irbs_pkg::ACT_SEND_BYTE;
            rsp.tx_byte = dout_q;
          end
          irbs_pkg::PH_SEND_STOP: begin
            phase_d    = irbs_pkg::PH_IDLE;
            wr_fin_d   = 1'b1;
            rsp.action = irbs_pkg::ACT_SEND_STOP;
          end
          irbs_pkg::PH_RESTART: begin
            phase_d    = irbs_pkg::PH_AWAIT_RX;
            rsp.action = irbs_pkg::ACT_RESTART;
          end
          default: begin
            // idle or waiting for the read byte: nothing to send
          end
        endcase
      end
      irbs_pkg::OP_RX_READY: begin
        if (phase_q == irbs_pkg::PH_AWAIT_RX) begin
          phase_d   = irbs_pkg::PH_IDLE;
          din_d     = item_i.rx_byte;
          is_read_d = 1'b0;
          rd_fin_d  = 1'b1;
        end
      end
      irbs_pkg::OP_NACK: begin
        rsp.action         = irbs_pkg::ACT_RESEND;
        rsp.target_address = slave_q;
      end
      irbs_pkg::OP_POLL: begin
        // write completion wins when both are pending
        if (armed_q && wr_fin_q) begin
          wr_fin_d       = 1'b0;
          armed_d        = 1'b0;
          rsp.write_done = 1'b1;
        end else if (armed_q && rd_fin_q) begin
          rd_fin_d      = 1'b0;
          armed_d       = 1'b0;
          rsp.read_done = 1'b1;
          rsp.read_data = din_q;
        end
      end
      default: begin
        // unused codes leave everything untouched
      end
    endcase
  end

  // state moves only when the event moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= irbs_pkg::PH_IDLE;
      is_read_q <= 1'b0;
      wr_fin_q  <= 1'b0;
      rd_fin_q  <= 1'b0;
      armed_q   <= 1'b0;
      slave_q   <= '0;
      reg_q     <= '0;
      dout_q    <= '0;
      din_q     <= '0;
    end else if (ctl_i.advance) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      wr_fin_q  <= wr_fin_d;
      rd_fin_q  <= rd_fin_d;
      armed_q   <= armed_d;
      slave_q   <= slave_d;
      reg_q     <= reg_d;
      dout_q    <= dout_d;
      din_q     <= din_d;
    end
  end

  assign rsp_o = rsp;

  // phase never leaves the defined range
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= irbs_pkg::PH_AWAIT_RX)
    else $error("sequencer phase out of range");

  // a completion report disarms polling
  a_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance && (rsp.write_done || rsp.read_done) |=> !armed_q)
    else $error("polling still armed after a completion report");

  // at most one completion per beat
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp.write_done && rsp.read_done))
    else $error("write and read completion in one beat");

  // a captured read byte is held for the poll report
  a_rx_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance && item_i.op == irbs_pkg::OP_RX_READY
      && phase_q == irbs_pkg::PH_AWAIT_RX
    |=> rd_fin_q && din_q == $past(item_i.rx_byte))
    else $error("read byte not captured");

endmodule

@@ hdl/irbs_out_reg.sv @@
// Result register: holds one result beat until the sink takes it.
// Depends on irbs_pkg and irbs_rsp_if.
module irbs_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  irbs_pkg::rsp_t       rsp_i,
  output logic                 space_o,
  irbs_rsp_if.source           rsp
);

  logic           valid_q, valid_d;
  irbs_pkg::rsp_t data_q;

  // free when empty or when the held beat is taken this cycle
  assign space_o = !valid_q || rsp.ready;
  assign valid_d = valid_i || (valid_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && space_o) begin
      data_q <= rsp_i;
    end
  end

  assign rsp.valid = valid_q;
  assign rsp.data  = data_q;

endmodule

@@ hdl/i2c_register_byte_sequencer_unit.sv @@
// Top level of the I2C register byte sequencer: input register, core, result register.
// Depends on irbs_pkg, irbs_if, irbs_in_reg, irbs_seq_core, irbs_out_reg.
//
//   channel | dir | beat                                  | handshake
//   --------+-----+---------------------------------------+-------------
//   req     | in  | op, device/register address, data, rx | valid/ready
//   rsp     | out | action, target, tx byte, done flags   | valid/ready
//
// One event beat per cycle while the result register has space; each gives exactly
// one result beat, registered in the input register and then the result register.
// The sequencer state updates as an event moves into the result register.
// rst_ni clears the stage valids and all sequencer state.
// With rsp.ready low, results hold and req.ready drops once both stages are full.
module i2c_register_byte_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  irbs_req_if.sink   req,
  irbs_rsp_if.source rsp
);

  irbs_pkg::stage_ctl_t ctl;
  irbs_pkg::req_t       item;
  irbs_pkg::rsp_t       result;
  logic                 item_valid;
  logic                 space;

  assign ctl.space   = space;
  assign ctl.advance = item_valid && space;

  irbs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .ctl_i   (ctl),
    .valid_o (item_valid),
    .item_o  (item)
  );

  irbs_seq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .rsp_o  (result)
  );

  irbs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .rsp_i   (result),
    .space_o (space),
    .rsp     (rsp)
  );

endmodule
